### rtl/vda_pkg.sv
`default_nettype none
package vda_pkg;

  localparam int unsigned DIM_X  = 64;
  localparam int unsigned DIM_Y  = 64;
  localparam int unsigned DIM_Z  = 64;
  localparam int unsigned VOXELS = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned VA_W   = (VOXELS > 1) ? $clog2(VOXELS) : 1;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned PIT_W  = 16;
  localparam int unsigned IDX_W  = 18;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned QW     = 8;   // quotient bits, index < 256
  localparam int unsigned SPAN_W = PIT_W + QW + 1;
  localparam int unsigned REM_W  = SPAN_W + 1;
  localparam int unsigned DIV_W  = PIT_W + 1;
  localparam int unsigned ZR_W   = POS_W + 2;
  localparam int unsigned U_W    = ZR_W + 3;
  localparam int unsigned CIDX_W = 3;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_HIT   = 2'd1;
  localparam logic [1:0] CMD_RDSUM = 2'd2;
  localparam logic [1:0] CMD_RDCNT = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_PITX   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_PITY   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_PITZ   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ZOFS   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ZLOW   = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_ZHIGH  = 3'd6;

  function automatic logic [VA_W-1:0] flat_index(input logic [QW-1:0] ix,
                                                 input logic [QW-1:0] iy,
                                                 input logic [QW-1:0] iz);
    logic [31:0] f;
    f = (32'(ix) * 32'(DIM_Y) + 32'(iy)) * 32'(DIM_Z) + 32'(iz);
    return f[VA_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/vda_if.sv
`default_nettype none
interface vda_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        energy;
  logic [17:0]        read_index;
  modport source (output valid, command, pos_x, pos_y, pos_z, energy, read_index,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, energy, read_index,
                output ready);
endinterface

interface vda_out_if;
  logic        valid;
  logic        ready;
  logic        hit_scored;
  logic [17:0] voxel_index;
  logic        event_accepted;
  logic [47:0] read_value;
  modport source (output valid, hit_scored, voxel_index, event_accepted, read_value,
                  input ready);
  modport sink (input valid, hit_scored, voxel_index, event_accepted, read_value,
                output ready);
endinterface

interface vda_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/vda_ram.sv
`default_nettype none
module vda_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 262144
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                  wdata_i,
  output logic      [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

### rtl/voxel_dose_accumulator_top.sv
// a start or count read goes from idle to done, a valid voxel read passes the read
// state, and a hit inside the grid passes locate, the three radix-2 pitch
// dividers, address and read-modify-write states; one word at a time: the next
// word is taken once the previous one sits in the output register
// after reset the voxel memory is swept to zero, one entry a cycle (all VOXELS
// entries, 262144 for a 64x64x64 grid); input ready stays low until it is done
`default_nettype none
module voxel_dose_accumulator_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  vda_in_if.sink   in_i,
  vda_cfg_if.sink  cfg_i,
  vda_out_if.source out_o
);
  import vda_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ADR  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration
  logic                     mode_q;
  logic [PIT_W-1:0]         pit_x_q, pit_y_q, pit_z_q;
  logic signed [POS_W-1:0]  zofs_q, zlow_q, zhigh_q;

  // event state
  logic [CNT_W-1:0]         evcnt_q;
  logic signed [POS_W-1:0]  refz_q;
  logic                     evopen_q, evcnt_done_q;

  // item registers
  logic                     is_hit_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic signed [ZR_W-1:0]   zrel_q;
  logic [POS_W-1:0]         energy_q;
  logic [REM_W-1:0]         rem_x_q, rem_y_q, rem_z_q;
  logic [QW-1:0]            qx_q, qy_q, qz_q;
  logic [2:0]               dcnt_q;
  logic [VA_W-1:0]          addr_q;
  logic [VA_W-1:0]          clr_q;

  // result under construction and output register
  logic                     r_hit_q, r_acc_q;
  logic [IDX_W-1:0]         r_idx_q;
  logic [SUM_W-1:0]         r_val_q;
  logic                     ov_q;
  logic                     o_hit_q, o_acc_q;
  logic [IDX_W-1:0]         o_idx_q;
  logic [SUM_W-1:0]         o_val_q;

  // memory port
  logic                     ram_we;
  logic [VA_W-1:0]          ram_addr;
  logic [SUM_W-1:0]         ram_wdata, ram_rdata;

  vda_ram #(.WIDTH(SUM_W), .DEPTH(VOXELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic in_acc, out_acc, cfg_acc;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  assign out_o.valid          = ov_q;
  assign out_o.hit_scored     = o_hit_q;
  assign out_o.voxel_index    = o_idx_q;
  assign out_o.event_accepted = o_acc_q;
  assign out_o.read_value     = o_val_q;

  // shift to grid origin, doubled coordinates
  logic [SPAN_W-1:0]      span_x, span_y, span_z;
  logic signed [U_W-1:0]  u_x, u_y, u_z;
  logic                   in_x, in_y, in_z;
  always_comb begin
    span_x = SPAN_W'(pit_x_q) * SPAN_W'(DIM_X);
    span_y = SPAN_W'(pit_y_q) * SPAN_W'(DIM_Y);
    span_z = SPAN_W'(pit_z_q) * SPAN_W'(DIM_Z);
    u_x = (U_W'(px_q) <<< 1) + $signed(U_W'(span_x));
    u_y = (U_W'(py_q) <<< 1) + $signed(U_W'(span_y));
    u_z = (U_W'(zrel_q) <<< 1) + $signed(U_W'(span_z));
    in_x = !u_x[U_W-1] && (u_x < $signed(U_W'({span_x, 1'b0})));
    in_y = !u_y[U_W-1] && (u_y < $signed(U_W'({span_y, 1'b0})));
    in_z = !u_z[U_W-1] && (u_z < $signed(U_W'({span_z, 1'b0})));
  end

  // one restoring step per axis and cycle
  logic [REM_W:0] tr_x, tr_y, tr_z;
  always_comb begin
    tr_x = {1'b0, rem_x_q} - ((REM_W+1)'({pit_x_q, 1'b0}) << dcnt_q);
    tr_y = {1'b0, rem_y_q} - ((REM_W+1)'({pit_y_q, 1'b0}) << dcnt_q);
    tr_z = {1'b0, rem_z_q} - ((REM_W+1)'({pit_z_q, 1'b0}) << dcnt_q);
  end

  logic [SUM_W:0] sum_ext;
  logic           gate;
  logic           ridx_ok;
  assign sum_ext = {1'b0, ram_rdata} + (SUM_W+1)'(energy_q);
  assign gate    = !mode_q || ((in_i.pos_z >= zlow_q) && (in_i.pos_z < zhigh_q));
  assign ridx_ok = 32'(in_i.read_index) < 32'(VOXELS);

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;
    unique case (state_q)
      ST_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        if (clr_q == VA_W'(VOXELS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        ram_addr = VA_W'(in_i.read_index);
        if (in_acc) begin
          if (in_i.command == CMD_HIT && evopen_q) state_d = ST_LOC;
          else if (in_i.command == CMD_RDSUM && ridx_ok) state_d = ST_RD;
          else state_d = ST_DONE;
        end
      end
      ST_LOC: state_d = (in_x && in_y && in_z) ? ST_DIV : ST_DONE;
      ST_DIV: if (dcnt_q == 3'd0) state_d = ST_ADR;
      ST_ADR: begin
        ram_addr = flat_index(qx_q, qy_q, qz_q);
        state_d  = ST_RD;
      end
      ST_RD: begin
        ram_we    = is_hit_q;
        ram_wdata = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        state_d   = ST_DONE;
      end
      ST_DONE: if (!ov_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_q        <= '0;
      mode_q       <= 1'b1;
      pit_x_q      <= 16'd256;
      pit_y_q      <= 16'd256;
      pit_z_q      <= 16'd256;
      zofs_q       <= '0;
      zlow_q       <= '0;
      zhigh_q      <= '0;
      evcnt_q      <= '0;
      refz_q       <= '0;
      evopen_q     <= 1'b0;
      evcnt_done_q <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) clr_q <= clr_q + VA_W'(1);
      if (cfg_acc) begin
        unique case (cfg_i.index)
          CFG_MODE:  mode_q  <= cfg_i.data[0];
          CFG_PITX:  pit_x_q <= cfg_i.data[PIT_W-1:0];
          CFG_PITY:  pit_y_q <= cfg_i.data[PIT_W-1:0];
          CFG_PITZ:  pit_z_q <= cfg_i.data[PIT_W-1:0];
          CFG_ZOFS:  zofs_q  <= cfg_i.data;
          CFG_ZLOW:  zlow_q  <= cfg_i.data;
          CFG_ZHIGH: zhigh_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_acc && in_i.command == CMD_START) begin
        refz_q       <= in_i.pos_z;
        evopen_q     <= gate;
        evcnt_done_q <= 1'b0;
      end
      if (in_acc && in_i.command == CMD_HIT && evopen_q && !evcnt_done_q) begin
        evcnt_done_q <= 1'b1;
        if (evcnt_q != {CNT_W{1'b1}}) evcnt_q <= evcnt_q + CNT_W'(1);
      end
      if (state_q == ST_DONE && (!ov_q || out_o.ready)) ov_q <= 1'b1;
      else if (out_acc) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_hit_q <= (in_i.command == CMD_HIT);
      px_q     <= in_i.pos_x;
      py_q     <= in_i.pos_y;
      zrel_q   <= ZR_W'(zofs_q) + ZR_W'(in_i.pos_z) - ZR_W'(refz_q);
      energy_q <= in_i.energy;
      addr_q   <= VA_W'(in_i.read_index);
      r_hit_q  <= 1'b0;
      r_idx_q  <= (in_i.command == CMD_RDSUM) ? in_i.read_index : '0;
      r_val_q  <= (in_i.command == CMD_RDCNT) ? SUM_W'(evcnt_q) : '0;
      r_acc_q  <= (in_i.command == CMD_START) ? gate : evopen_q;
    end
    if (state_q == ST_LOC) begin
      rem_x_q <= REM_W'(u_x);
      rem_y_q <= REM_W'(u_y);
      rem_z_q <= REM_W'(u_z);
      dcnt_q  <= 3'(QW - 1);
    end
    if (state_q == ST_DIV) begin
      qx_q[dcnt_q] <= !tr_x[REM_W];
      qy_q[dcnt_q] <= !tr_y[REM_W];
      qz_q[dcnt_q] <= !tr_z[REM_W];
      if (!tr_x[REM_W]) rem_x_q <= tr_x[REM_W-1:0];
      if (!tr_y[REM_W]) rem_y_q <= tr_y[REM_W-1:0];
      if (!tr_z[REM_W]) rem_z_q <= tr_z[REM_W-1:0];
      dcnt_q <= dcnt_q - 3'd1;
    end
    if (state_q == ST_ADR) begin
      addr_q  <= flat_index(qx_q, qy_q, qz_q);
      r_idx_q <= IDX_W'(flat_index(qx_q, qy_q, qz_q));
    end
    if (state_q == ST_RD) begin
      if (is_hit_q) r_hit_q <= 1'b1;
      else r_val_q <= ram_rdata;
    end
    if (state_q == ST_DONE && (!ov_q || out_o.ready)) begin
      o_hit_q <= r_hit_q;
      o_idx_q <= r_idx_q;
      o_acc_q <= r_acc_q;
      o_val_q <= r_val_q;
    end
  end

endmodule
`default_nettype wire

### rtl/vda_checker.sv
`default_nettype none
module vda_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        hit_scored,
  input wire logic [17:0] voxel_index,
  input wire logic        event_accepted,
  input wire logic [47:0] read_value
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(voxel_index) && $stable(read_value))
    else $error("output word changed while stalled");

  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous word in flight");

  a_scored_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && hit_scored |-> event_accepted && (read_value == 48'd0))
    else $error("scored hit outside an open event or with read data");

endmodule

bind voxel_dose_accumulator_top vda_checker u_vda_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .hit_scored     (out_o.hit_scored),
  .voxel_index    (out_o.voxel_index),
  .event_accepted (out_o.event_accepted),
  .read_value     (out_o.read_value)
);
`default_nettype wire
